// ===== rtl/core/dddc_pkg.sv =====
// Package for the date day difference core: widths, date type and day-number function.
`timescale 1ns / 1ps

package dddc_pkg;

  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 7;
  localparam int unsigned DayNumW = 16;
  localparam int unsigned GapW    = 16;
  localparam int unsigned CumW    = 9;

  // Year offset of 2100, the only century year in range that is not a leap year.
  localparam logic [YearW-1:0] NoLeapCentury = YearW'(100);

  // Days before the given month in a common year; month 0 acts as month 1,
  // months 13 to 15 count the whole year.
  localparam logic [CumW-1:0] CumDays [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t first;
    date_t second;
  } date_pair_t;

  function automatic logic [DayNumW-1:0] day_number(date_t dt);
    logic [DayNumW-1:0] year_days;
    logic [5:0]         leap_days;
    logic               leap;
    logic               past_century;
    begin
      year_days    = DayNumW'(dt.year) * DayNumW'(365);
      // leap years in [2000, 2000+y): every fourth from 2000, minus 2100 once passed
      leap_days    = 6'((8'(dt.year) + 8'd3) >> 2);
      past_century = dt.year > NoLeapCentury;
      leap         = (dt.year[1:0] == 2'b00) && (dt.year != NoLeapCentury);
      day_number   = year_days + DayNumW'(leap_days) - DayNumW'(past_century)
                   + DayNumW'(CumDays[dt.month])
                   + DayNumW'(leap && (dt.month >= MonthW'(3)))
                   + DayNumW'(dt.day);
    end
  endfunction

endpackage

// ===== rtl/core/date_day_difference_core.sv =====
// Top level: two-stage pipeline computing the day gap between two dates.
`timescale 1ns / 1ps

// Takes a pair of dates (year offset from 2000, month, day) per request and
// returns the absolute difference of their Gregorian day numbers plus a flag
// that is high when the first date is not earlier than the second. One request
// is accepted every cycle unless both stages are full and the output is stalled;
// the request passes through the input register, the day-number and subtract
// logic and the result register. Months 0 and 1 add no month days, months 13
// to 15 add a full year; days are added unchecked. Nothing is configured and
// no state survives between requests.
module date_day_difference_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dddc_pkg::YearW-1:0]   first_year_i,
  input  logic [dddc_pkg::MonthW-1:0]  first_month_i,
  input  logic [dddc_pkg::DayW-1:0]    first_day_i,
  input  logic [dddc_pkg::YearW-1:0]   second_year_i,
  input  logic [dddc_pkg::MonthW-1:0]  second_month_i,
  input  logic [dddc_pkg::DayW-1:0]    second_day_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         first_not_earlier_o,
  output logic [dddc_pkg::GapW-1:0]    day_gap_o
);

  logic                           in_valid_q;
  dddc_pkg::date_pair_t           in_q;
  logic                           out_valid_q;
  logic                           flag_q;
  logic [dddc_pkg::GapW-1:0]      gap_q;

  logic                           out_stage_ready;
  logic [dddc_pkg::DayNumW-1:0]   num_first;
  logic [dddc_pkg::DayNumW-1:0]   num_second;
  logic                           flag_d;
  logic [dddc_pkg::GapW-1:0]      gap_d;

  assign out_stage_ready = !out_valid_q || out_ready_i;
  assign in_ready_o      = !in_valid_q || out_stage_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.first.year   <= first_year_i;
      in_q.first.month  <= first_month_i;
      in_q.first.day    <= first_day_i;
      in_q.second.year  <= second_year_i;
      in_q.second.month <= second_month_i;
      in_q.second.day   <= second_day_i;
    end
  end

  always_comb begin
    num_first  = dddc_pkg::day_number(in_q.first);
    num_second = dddc_pkg::day_number(in_q.second);
    flag_d     = num_first >= num_second;
    gap_d      = flag_d ? dddc_pkg::GapW'(num_first - num_second)
                        : dddc_pkg::GapW'(num_second - num_first);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_stage_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_stage_ready && in_valid_q) begin
      flag_q <= flag_d;
      gap_q  <= gap_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign first_not_earlier_o = flag_q;
  assign day_gap_o           = gap_q;

  // Back-pressure only when both stages hold a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a stage is free");

  // An accepted request always lands in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> in_valid_q)
    else $error("accepted request lost at input register");

  // A held request moves into a free result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_stage_ready) |=> out_valid_q)
    else $error("request not advanced to result register");

  // A first date that is earlier must give a nonzero gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !first_not_earlier_o) |-> (day_gap_o != '0))
    else $error("zero gap with first date flagged earlier");

endmodule
